// ----- hdl/f2o8_pkg.sv -----
// ----------------------------------------------------------------------------
// f2o8_pkg: shared types and constants for FP32 to FP8 narrowing conversion
// ----------------------------------------------------------------------------
`default_nettype none
package f2o8_pkg;
	localparam logic [7:0] NAN_CODE = 8'h7F;
	localparam logic [7:0] E4M3_MAX = 8'h7E;
	localparam logic [7:0] E5M2_INF = 8'h7C;
	localparam logic [7:0] E5M2_MAX = 8'h7B;

	localparam logic OP_E4M3 = 1'b0;
	localparam logic OP_E5M2 = 1'b1;

	// class of an item after decode
	typedef enum logic [1:0] {
		CLS_NAN,
		CLS_OVF,
		CLS_ZERO,
		CLS_NUM
	} cls_t;

	// stage 1 -> stage 2 bundle
	typedef struct packed {
		cls_t        cls;
		logic        sign;
		logic        e5m2;
		logic        sat;
		logic [4:0]  efield;
		logic [5:0]  shift;  // 20..26, set to 25 when below the minimum normal by more than 5
		logic [23:0] sig;
	} dec_t;

	// stage 2 -> stage 3 bundle
	typedef struct packed {
		cls_t       cls;
		logic       sign;
		logic       e5m2;
		logic       sat;
		logic [4:0] efield;
		logic [3:0] q;       // truncated significand
		logic       rnd_up;
	} rnd_t;
endpackage
`default_nettype wire

// ----- hdl/f2o8_decode.sv -----
// ----------------------------------------------------------------------------
// f2o8_decode: unpack FP32, classify, find exponent field and shift amount
// ----------------------------------------------------------------------------
`default_nettype none
module f2o8_decode (
	input  wire logic [31:0] value,
	input  wire logic        operation,
	input  wire logic        saturate,
	output f2o8_pkg::dec_t   dec
);
	logic [7:0] bexp;
	logic [8:0] emin_b;   // biased minimum normal exponent
	logic [8:0] diff;

	always_comb begin
		bexp   = value[30:23];
		emin_b = (operation == f2o8_pkg::OP_E5M2) ? 9'd113 : 9'd121;
		diff   = {1'b0, bexp} - emin_b;
		dec.sign   = value[31];
		dec.e5m2   = operation;
		dec.sat    = saturate;
		dec.sig    = {1'b1, value[22:0]};
		dec.efield = '0;
		dec.shift  = (operation == f2o8_pkg::OP_E5M2) ? 6'd21 : 6'd20;
		if (bexp == 8'hFF) begin
			dec.cls = (value[22:0] != '0) ? f2o8_pkg::CLS_NAN : f2o8_pkg::CLS_OVF;
		end else if (bexp == 8'h00) begin
			dec.cls = f2o8_pkg::CLS_ZERO;
		end else if ({1'b0, bexp} >= emin_b) begin
			dec.cls = (diff > 9'd20) ? f2o8_pkg::CLS_OVF : f2o8_pkg::CLS_NUM;
			dec.efield = diff[4:0];
		end else begin
			dec.cls = f2o8_pkg::CLS_NUM;
			// emin_b - bexp added to base shift; a difference above 5 gives 25
			if ((emin_b - {1'b0, bexp}) > 9'd5) dec.shift = 6'd25;
			else dec.shift = dec.shift + 6'((emin_b - {1'b0, bexp}));
		end
	end
endmodule
`default_nettype wire

// ----- hdl/f2o8_round.sv -----
// ----------------------------------------------------------------------------
// f2o8_round: shift significand, form round-to-nearest-even increment
// ----------------------------------------------------------------------------
`default_nettype none
module f2o8_round (
	input  f2o8_pkg::dec_t dec,
	output f2o8_pkg::rnd_t rnd
);
	logic [23:0] q;
	logic [23:0] mask;
	logic [23:0] rem;
	logic [23:0] half;

	always_comb begin
		q    = dec.sig >> dec.shift;
		mask = (24'd1 << dec.shift) - 24'd1;
		rem  = dec.sig & mask;
		half = 24'd1 << (dec.shift - 6'd1);
		rnd.cls    = dec.cls;
		rnd.sign   = dec.sign;
		rnd.e5m2   = dec.e5m2;
		rnd.sat    = dec.sat;
		rnd.efield = dec.efield;
		rnd.q      = q[3:0];
		rnd.rnd_up = (rem > half) || ((rem == half) && q[0]);
		if (dec.shift >= 6'd25) begin
			rnd.q      = '0;
			rnd.rnd_up = 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/f2o8_pack.sv -----
// ----------------------------------------------------------------------------
// f2o8_pack: assemble code, overflow check, special results
// ----------------------------------------------------------------------------
`default_nettype none
module f2o8_pack (
	input  f2o8_pkg::rnd_t   rnd,
	output logic [7:0]       result
);
	logic [7:0] ovf;
	logic [7:0] maxc;
	logic [7:0] code;

	always_comb begin
		maxc = rnd.e5m2 ? f2o8_pkg::E5M2_MAX : f2o8_pkg::E4M3_MAX;
		if (rnd.sat) ovf = {rnd.sign, maxc[6:0]};
		else if (rnd.e5m2) ovf = {rnd.sign, f2o8_pkg::E5M2_INF[6:0]};
		else ovf = f2o8_pkg::NAN_CODE;
		code = (rnd.e5m2 ? {1'b0, rnd.efield, 2'b00} : {rnd.efield, 3'b000})
			+ {4'd0, rnd.q} + {7'd0, rnd.rnd_up};
		unique case (rnd.cls)
			f2o8_pkg::CLS_NAN:  result = f2o8_pkg::NAN_CODE;
			f2o8_pkg::CLS_OVF:  result = ovf;
			f2o8_pkg::CLS_ZERO: result = {rnd.sign, 7'd0};
			default:            result = (code > maxc) ? ovf : {rnd.sign, code[6:0]};
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/fp32_to_ofp8_narrowing_convert.sv -----
// ----------------------------------------------------------------------------
// fp32_to_ofp8_narrowing_convert: FP32 to FP8 (E4M3 / E5M2), RNE, saturation
// ----------------------------------------------------------------------------
// Pipeline: decode, round and pack stages, each ending in a register.
// Throughput: one beat per cycle; all stages advance together unless the
// output is full and not taken, which stalls the whole pipe.
// Reset: arst_n clears the stage valid bits only; payload is not reset.
`default_nettype none
module fp32_to_ofp8_narrowing_convert (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // value[31:0], operation[32], saturate[33], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // result[7:0]
);
	f2o8_pkg::dec_t dec_c, dec_s1;
	f2o8_pkg::rnd_t rnd_c, rnd_s2;
	logic [7:0]     res_c, res_s3;
	logic           v_s1, v_s2, v_s3;
	logic           adv;

	// pipe moves whenever the last stage is empty or being drained
	assign adv      = !v_s3 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s3;
	assign m_tdata  = res_s3;

	f2o8_decode u_dec (
		.value(s_tdata[31:0]), .operation(s_tdata[32]), .saturate(s_tdata[33]),
		.dec(dec_c)
	);
	f2o8_round u_rnd (.dec(dec_s1), .rnd(rnd_c));
	f2o8_pack  u_pck (.rnd(rnd_s2), .result(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec_c;
			rnd_s2 <= rnd_c;
			res_s3 <= res_c;
		end
	end
endmodule
`default_nettype wire
